// ===== hdl/rlebc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlebc_pkg
// Shared types, constants and helpers of the run-length byte compressor.
// ----------------------------------------------------------------------------
package rlebc_pkg;

  // Default longest run or literal sequence; the length must fit a header byte
  localparam int MAX_RUN_LENGTH_DEF = 31;

  // Command queue between front and back (power of two, pointers wrap)
  localparam int CMDQ_DEPTH = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_FLAG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_FLAG = 1'b1;

  // Configuration reset values
  localparam logic [7:0] RUN_FLAG_RST = 8'h80;
  localparam logic [7:0] SEQ_FLAG_RST = 8'h00;

  typedef logic [7:0] byte_t;

  // One unit of output work: a literal sequence or a run
  typedef struct packed {
    logic  is_seq;   // 1: literal sequence, 0: run
    logic  bank;     // literal buffer bank holding the sequence
    byte_t len;      // length ORed into the header
    byte_t run_byte; // repeated byte of a run
    logic  last;     // this command ends the item's output
  } cmd_t;

  // Back tells front that a literal bank has been read out
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic cmd_t mk_seq(input logic bank, input byte_t len, input logic last);
    cmd_t c;
    c.is_seq   = 1'b1;
    c.bank     = bank;
    c.len      = len;
    c.run_byte = '0;
    c.last     = last;
    return c;
  endfunction

  function automatic cmd_t mk_run(input byte_t len, input byte_t b, input logic last);
    cmd_t c;
    c.is_seq   = 1'b0;
    c.bank     = 1'b0;
    c.len      = len;
    c.run_byte = b;
    c.last     = last;
    return c;
  endfunction

endpackage

// ===== hdl/rle_byte_compressor.sv =====
// ----------------------------------------------------------------------------
// rle_byte_compressor
// Byte-stream run-length compressor with 8-bit sequence and run headers.
// ----------------------------------------------------------------------------
// A beat that breaks a run of one or two bytes into literals writes the first
// into the buffer and holds the front in its fill state, which writes the
// rest one at a time. The back sends one output byte per cycle while
// out_tready is high: a run is two bytes, a literal sequence its header plus
// up to MAX_RUN_LENGTH bytes, read from a two-bank literal buffer through one
// registered read port. The front stalls when the queue has fewer than two
// free slots or when the literal bank it would write is still being read
// out, so long sequences drain at the output rate of one byte per cycle. The
// last byte produced for an input beat carries out_tlast. Configuration writes
// take effect at once (cfg_ready is always high) and belong to idle periods.
// ----------------------------------------------------------------------------
module rle_byte_compressor
  import rlebc_pkg::*;
#(
  parameter int MAX_RUN_LENGTH = MAX_RUN_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] in_byte
  input  logic                 in_tuser,   // [0] func (1 = flush)
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic                 out_tlast,  // last_of_burst
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int IW = $clog2(MAX_RUN_LENGTH);

  logic          push_a, push_b, pop, q_empty, q_space2;
  cmd_t          cmd_a, cmd_b, head;
  rel_t          rel;
  logic          wr_en, wr_bank;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;

  rlebc_front #(
    .MAX_RUN_LENGTH(MAX_RUN_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_space2  (q_space2),
    .push_a    (push_a),
    .cmd_a     (cmd_a),
    .push_b    (push_b),
    .cmd_b     (cmd_b),
    .rel       (rel),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  rlebc_cmd_fifo u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_a (push_a),
    .cmd_a  (cmd_a),
    .push_b (push_b),
    .cmd_b  (cmd_b),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty),
    .space2 (q_space2)
  );

  rlebc_back #(
    .MAX_RUN_LENGTH(MAX_RUN_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr_en      (wr_en),
    .wr_bank    (wr_bank),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/rlebc_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rlebc_cmd_fifo
// Small command queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module rlebc_cmd_fifo
  import rlebc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_a,
  input  cmd_t cmd_a,
  input  logic push_b,
  input  cmd_t cmd_b,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic space2
);

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t          q_r [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic [PW:0]   n_push;
  logic [PW-1:0] wr_ptr_b;

  assign n_push   = (PW+1)'(push_a) + (PW+1)'(push_b);
  assign wr_ptr_b = wr_ptr_r + PW'(1);

  assign head   = q_r[rd_ptr_r];
  assign empty  = (count_r == '0);
  assign space2 = (count_r <= (PW+1)'(CMDQ_DEPTH - 2));

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[PW-1:0];
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + n_push - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_a) q_r[wr_ptr_r] <= cmd_a;
    if (push_b) q_r[wr_ptr_b] <= cmd_b;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r + n_push) <= (PW+1)'(CMDQ_DEPTH))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue pop while empty");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push_b |-> push_a)
    else $error("second push without first");

endmodule

// ===== hdl/rlebc_front.sv =====
// ----------------------------------------------------------------------------
// rlebc_front
// Accepts input beats, tracks the pending run and literal count, writes
// literals into a two-bank buffer and queues sequence and run commands.
// ----------------------------------------------------------------------------
module rlebc_front
  import rlebc_pkg::*;
#(
  parameter int MAX_RUN_LENGTH = MAX_RUN_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  input  logic                              in_tuser,
  input  logic                              q_space2,
  output logic                              push_a,
  output cmd_t                              cmd_a,
  output logic                              push_b,
  output cmd_t                              cmd_b,
  input  rel_t                              rel,
  output logic                              wr_en,
  output logic                              wr_bank,
  output logic [$clog2(MAX_RUN_LENGTH)-1:0] wr_addr,
  output logic [7:0]                        wr_data
);

  localparam int CW = $clog2(MAX_RUN_LENGTH + 1);
  localparam int IW = $clog2(MAX_RUN_LENGTH);
  localparam logic [CW-1:0] LAST_CNT = CW'(MAX_RUN_LENGTH - 1);
  localparam byte_t FULL_LEN = 8'(MAX_RUN_LENGTH);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_FILL = 2'b10
  } fst_t;

  fst_t          st_r, st_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt, busy_set, busy_clr;
  logic [CW-1:0] lit_cnt_r, lit_cnt_nxt;
  logic [CW-1:0] run_cnt_r, run_cnt_nxt;
  byte_t         run_byte_r, run_byte_nxt;
  byte_t         last_lit_r, last_lit_nxt;
  logic [1:0]    fill_idx_r, fill_idx_nxt;
  logic [1:0]    fill_end_r, fill_end_nxt;
  byte_t         fill_byte_r, fill_byte_nxt;
  byte_t         fill_c_r, fill_c_nxt;
  logic          acc;

  assign in_tready = (st_r == F_IDLE) && !busy_r[bank_r] && q_space2;
  assign acc       = in_tvalid && in_tready;

  // bank release from the back
  always_comb begin
    busy_clr = '0;
    if (rel.valid) busy_clr[rel.bank] = 1'b1;
  end

  // item classification and state update
  always_comb begin
    st_nxt        = st_r;
    bank_nxt      = bank_r;
    busy_set      = '0;
    lit_cnt_nxt   = lit_cnt_r;
    run_cnt_nxt   = run_cnt_r;
    run_byte_nxt  = run_byte_r;
    last_lit_nxt  = last_lit_r;
    fill_idx_nxt  = fill_idx_r;
    fill_end_nxt  = fill_end_r;
    fill_byte_nxt = fill_byte_r;
    fill_c_nxt    = fill_c_r;
    push_a        = 1'b0;
    push_b        = 1'b0;
    cmd_a         = mk_run('0, '0, 1'b0);
    cmd_b         = mk_run('0, '0, 1'b0);
    wr_en         = 1'b0;
    wr_bank       = bank_r;
    wr_addr       = lit_cnt_r[IW-1:0];
    wr_data       = in_tdata;
    unique case (st_r)
      F_IDLE: begin
        if (acc) begin
          if (in_tuser) begin
            // flush: sequence first, then run
            if (lit_cnt_r != '0) begin
              push_a           = 1'b1;
              cmd_a            = mk_seq(bank_r, 8'(lit_cnt_r), run_cnt_r == '0);
              busy_set[bank_r] = 1'b1;
              bank_nxt         = ~bank_r;
              if (run_cnt_r != '0) begin
                push_b = 1'b1;
                cmd_b  = mk_run(8'(run_cnt_r), run_byte_r, 1'b1);
              end
            end else if (run_cnt_r != '0) begin
              push_a = 1'b1;
              cmd_a  = mk_run(8'(run_cnt_r), run_byte_r, 1'b1);
            end
            lit_cnt_nxt = '0;
            run_cnt_nxt = '0;
          end else if (lit_cnt_r == '0) begin
            if (run_cnt_r == '0) begin
              run_byte_nxt = in_tdata;
              run_cnt_nxt  = CW'(1);
            end else if (run_byte_r == in_tdata) begin
              if (run_cnt_r == LAST_CNT) begin
                push_a      = 1'b1;
                cmd_a       = mk_run(FULL_LEN, run_byte_r, 1'b1);
                run_cnt_nxt = '0;
              end else begin
                run_cnt_nxt = run_cnt_r + CW'(1);
              end
            end else if (run_cnt_r > CW'(2)) begin
              push_a       = 1'b1;
              cmd_a        = mk_run(8'(run_cnt_r), run_byte_r, 1'b1);
              run_cnt_nxt  = CW'(1);
              run_byte_nxt = in_tdata;
            end else begin
              // short run broken: becomes literals, written one per cycle
              wr_en         = 1'b1;
              wr_addr       = '0;
              wr_data       = run_byte_r;
              fill_idx_nxt  = 2'd1;
              fill_end_nxt  = run_cnt_r[1:0];
              fill_byte_nxt = run_byte_r;
              fill_c_nxt    = in_tdata;
              last_lit_nxt  = in_tdata;
              run_cnt_nxt   = '0;
              st_nxt        = F_FILL;
            end
          end else if (run_cnt_r != '0) begin
            if (in_tdata == run_byte_r) begin
              if (run_cnt_r == LAST_CNT) begin
                push_a           = 1'b1;
                cmd_a            = mk_seq(bank_r, 8'(lit_cnt_r), 1'b0);
                push_b           = 1'b1;
                cmd_b            = mk_run(FULL_LEN, run_byte_r, 1'b1);
                busy_set[bank_r] = 1'b1;
                bank_nxt         = ~bank_r;
                lit_cnt_nxt      = '0;
                run_cnt_nxt      = '0;
              end else begin
                run_cnt_nxt = run_cnt_r + CW'(1);
              end
            end else begin
              push_a           = 1'b1;
              cmd_a            = mk_seq(bank_r, 8'(lit_cnt_r), 1'b0);
              push_b           = 1'b1;
              cmd_b            = mk_run(8'(run_cnt_r), run_byte_r, 1'b1);
              busy_set[bank_r] = 1'b1;
              bank_nxt         = ~bank_r;
              lit_cnt_nxt      = '0;
              run_cnt_nxt      = CW'(1);
              run_byte_nxt     = in_tdata;
            end
          end else if (last_lit_r == in_tdata) begin
            // tail pair split off the sequence as a run of two
            run_byte_nxt = in_tdata;
            run_cnt_nxt  = CW'(2);
            lit_cnt_nxt  = lit_cnt_r - CW'(1);
          end else begin
            wr_en        = 1'b1;
            last_lit_nxt = in_tdata;
            if (lit_cnt_r == LAST_CNT) begin
              push_a           = 1'b1;
              cmd_a            = mk_seq(bank_r, FULL_LEN, 1'b1);
              busy_set[bank_r] = 1'b1;
              bank_nxt         = ~bank_r;
              lit_cnt_nxt      = '0;
            end else begin
              lit_cnt_nxt = lit_cnt_r + CW'(1);
            end
          end
        end
      end
      F_FILL: begin
        wr_en   = 1'b1;
        wr_addr = IW'(fill_idx_r);
        wr_data = (fill_idx_r == fill_end_r) ? fill_c_r : fill_byte_r;
        if (fill_idx_r == fill_end_r) begin
          st_nxt = F_IDLE;
          if (CW'(fill_end_r) == LAST_CNT) begin
            push_a           = 1'b1;
            cmd_a            = mk_seq(bank_r, FULL_LEN, 1'b1);
            busy_set[bank_r] = 1'b1;
            bank_nxt         = ~bank_r;
            lit_cnt_nxt      = '0;
          end else begin
            lit_cnt_nxt = CW'(fill_end_r) + CW'(1);
          end
        end else begin
          fill_idx_nxt = fill_idx_r + 2'd1;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
    busy_nxt = (busy_r & ~busy_clr) | busy_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= F_IDLE;
      bank_r     <= 1'b0;
      busy_r     <= '0;
      lit_cnt_r  <= '0;
      run_cnt_r  <= '0;
      run_byte_r <= '0;
    end else begin
      st_r       <= st_nxt;
      bank_r     <= bank_nxt;
      busy_r     <= busy_nxt;
      lit_cnt_r  <= lit_cnt_nxt;
      run_cnt_r  <= run_cnt_nxt;
      run_byte_r <= run_byte_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    last_lit_r  <= last_lit_nxt;
    fill_idx_r  <= fill_idx_nxt;
    fill_end_r  <= fill_end_nxt;
    fill_byte_r <= fill_byte_nxt;
    fill_c_r    <= fill_c_nxt;
  end

  a_lit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lit_cnt_r < CW'(MAX_RUN_LENGTH))
    else $error("literal count reached the maximum without a flush");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r < CW'(MAX_RUN_LENGTH))
    else $error("run count reached the maximum without a flush");

  a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_FILL) |-> (lit_cnt_r == '0 && run_cnt_r == '0))
    else $error("literal fill with pending state");

endmodule

// ===== hdl/rlebc_back.sv =====
// ----------------------------------------------------------------------------
// rlebc_back
// Holds the configuration flags and the literal buffer, walks each queued
// command one byte per cycle unless the output stalls, and drives the registered output stage.
// ----------------------------------------------------------------------------
module rlebc_back
  import rlebc_pkg::*;
#(
  parameter int MAX_RUN_LENGTH = MAX_RUN_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic                              wr_en,
  input  logic                              wr_bank,
  input  logic [$clog2(MAX_RUN_LENGTH)-1:0] wr_addr,
  input  logic [7:0]                        wr_data,
  input  cmd_t                              head,
  input  logic                              q_empty,
  output logic                              pop,
  output rel_t                              rel,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast
);

  localparam int IW = $clog2(MAX_RUN_LENGTH);

  byte_t   run_flag_r, seq_flag_r;
  byte_t   lit_mem_r [2][MAX_RUN_LENGTH];
  byte_t   rd_data_r;
  byte_t   pos_r, pos_nxt, pos_m1;
  logic    s1_valid_r, s1_mem_r, s1_last_r;
  byte_t   s1_byte_r;
  logic    iss;
  logic    tok_hdr, tok_end, tok_mem, tok_last;
  byte_t   tok_byte;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_flag_r <= RUN_FLAG_RST;
      seq_flag_r <= SEQ_FLAG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RUN_FLAG: run_flag_r <= cfg_data;
        REG_SEQ_FLAG: seq_flag_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next byte of the head command
  always_comb begin
    pos_m1   = pos_r - 8'd1;
    tok_hdr  = (pos_r == '0);
    tok_end  = head.is_seq ? (pos_r == head.len) : (pos_r == 8'd1);
    tok_mem  = head.is_seq && !tok_hdr;
    tok_last = head.last && tok_end;
    tok_byte = tok_hdr ? ((head.is_seq ? seq_flag_r : run_flag_r) | head.len)
                       : head.run_byte;
    iss      = !q_empty && (!s1_valid_r || out_tready);
    pop      = iss && tok_end;
    pos_nxt  = iss ? (tok_end ? 8'd0 : pos_r + 8'd1) : pos_r;
    rel.valid = iss && tok_mem && tok_end;
    rel.bank  = head.bank;
  end

  // literal buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) lit_mem_r[wr_bank][wr_addr] <= wr_data;
    if (iss && tok_mem) rd_data_r <= lit_mem_r[head.bank][pos_m1[IW-1:0]];
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (iss) s1_valid_r <= 1'b1;
      else if (out_tready) s1_valid_r <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (iss) begin
      s1_mem_r  <= tok_mem;
      s1_byte_r <= tok_byte;
      s1_last_r <= tok_last;
    end
  end

  assign out_tvalid = s1_valid_r;
  assign out_tdata  = s1_mem_r ? rd_data_r : s1_byte_r;
  assign out_tlast  = s1_last_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length byte compressor.
// ----------------------------------------------------------------------------
// A queue of pending beats feeds a clocked stream driver. Each accepted beat
// goes through a software model of the compressor, which queues the output
// bytes it should produce. A clocked monitor takes each output beat and
// checks it against the oldest queued byte. A short directed list comes
// first: extremes and several corners of the run/sequence logic. Random run,
// literal and noise segments follow under several flag settings. Both sides
// of the stream idle at random, with a calm stretch in every window.
// ----------------------------------------------------------------------------
module tb_top
  import rlebc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXLEN       = MAX_RUN_LENGTH_DEF;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYC   = 32;
  localparam int PHASE_ITEMS  = 8;

  typedef struct packed {
    logic  flush;
    byte_t data;
  } src_beat_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } out_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // [7:0] in_byte
  logic                 in_tuser = 1'b0; // [0] func (1 = flush)
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // [7:0] out_byte
  logic                 out_tlast;       // last_of_burst
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  rle_byte_compressor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bench bookkeeping
  src_beat_t pending_q[$];
  src_beat_t in_cur = '0;
  bit        in_took = 1'b0;
  int        n_queued = 0;
  int        err_cnt = 0;
  int        cyc = 0;

  // Compressor model state
  byte_t      lit_buf [MAXLEN];
  logic [4:0] lit_cnt = '0;
  logic [4:0] rep_cnt = '0;
  byte_t      rep_byte = '0;
  byte_t      run_hdr_flag = RUN_FLAG_RST;
  byte_t      seq_hdr_flag = SEQ_FLAG_RST;
  out_beat_t  burst_q[$];
  out_beat_t  exp_bytes_q[$];

  // Model output helpers: one burst is built per input beat
  function automatic void put_out(byte_t b);
    burst_q.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void write_seq();
    put_out(seq_hdr_flag | byte_t'(lit_cnt));
    for (int k = 0; k < lit_cnt; k++) put_out(lit_buf[k]);
  endfunction

  function automatic void write_run();
    put_out(run_hdr_flag | byte_t'(rep_cnt));
    put_out(rep_byte);
  endfunction

  function automatic void add_literal(byte_t b);
    if (lit_cnt >= MAXLEN) lit_cnt = '0;
    lit_buf[lit_cnt] = b;
    lit_cnt++;
    if (lit_cnt == MAXLEN) begin
      write_seq();
      lit_cnt = '0;
    end
  endfunction

  // Expected output bytes of one accepted input beat
  function automatic void compress_beat(src_beat_t it);
    out_beat_t tail;
    byte_t     c;
    c = it.data;
    burst_q.delete();
    if (it.flush) begin
      if (lit_cnt != 0) write_seq();
      if (rep_cnt != 0) write_run();
      lit_cnt = '0;
      rep_cnt = '0;
    end else if (lit_cnt == 0) begin
      if (rep_cnt == 0) begin
        rep_byte = c;
        rep_cnt  = 5'd1;
      end else if (rep_byte == c) begin
        rep_cnt++;
        if (rep_cnt >= MAXLEN) begin
          write_run();
          rep_cnt = '0;
        end
      end else if (rep_cnt > 2) begin
        write_run();
        rep_cnt  = 5'd1;
        rep_byte = c;
      end else begin
        // short run with no sequence: it turns into literals
        for (int k = 0; k < rep_cnt; k++) add_literal(rep_byte);
        rep_cnt = '0;
        add_literal(c);
      end
    end else if (rep_cnt != 0) begin
      if (c == rep_byte) begin
        rep_cnt++;
        if (rep_cnt >= MAXLEN) begin
          write_seq();
          write_run();
          lit_cnt = '0;
          rep_cnt = '0;
        end
      end else begin
        write_seq();
        write_run();
        lit_cnt  = '0;
        rep_cnt  = 5'd1;
        rep_byte = c;
      end
    end else if (lit_buf[lit_cnt - 1] == c) begin
      // pair at the sequence tail becomes a run of two
      rep_byte = c;
      rep_cnt  = 5'd2;
      lit_cnt--;
    end else begin
      add_literal(c);
    end
    if (burst_q.size() != 0) begin
      tail = burst_q.pop_back();
      tail.last = 1'b1;
      burst_q.push_back(tail);
    end
    foreach (burst_q[i]) exp_bytes_q.push_back(burst_q[i]);
  endfunction

  // Random idling, with a calm stretch in every window of the cycle counter
  function automatic bit take_break();
    if ((cyc % 2000) >= 300 && (cyc % 2000) < 700) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Input side: note accepted beats and model them
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      in_took = 1'b1;
      compress_beat(in_cur);
    end
  end

  // Input driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (pending_q.size() != 0 && !take_break()) begin
        in_cur = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= in_cur.data;
        in_tuser  <= in_cur.flush;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  // Output backpressure
  always @(negedge clk) begin
    out_tready <= rst_n && !take_break();
  end

  // Output monitor
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_bytes_q.size() == 0) begin
        $error("unexpected output beat: out_byte %02h last %0b", out_tdata, out_tlast);
        err_cnt++;
      end else begin
        want = exp_bytes_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte mismatch: expected %02h, got %02h", want.data, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_burst mismatch: expected %0b, got %0b", want.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  function automatic void queue_beat(logic f, byte_t d);
    pending_q.push_back('{flush: f, data: d});
    n_queued++;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RUN_FLAG: run_hdr_flag = val;
      REG_SEQ_FLAG: seq_hdr_flag = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every beat is sent and every output byte has come back
  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid) @(posedge clk);
    while (exp_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // One random segment: a run, a literal stretch, a flush or noise
  task automatic add_segment();
    int    kind;
    int    len;
    byte_t b;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      b   = byte_t'($urandom);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(29, 33) : $urandom_range(1, 5);
      repeat (len) queue_beat(1'b0, b);
    end else if (kind <= 6) begin
      b   = byte_t'($urandom);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(29, 33) : $urandom_range(1, 6);
      repeat (len) begin
        queue_beat(1'b0, b);
        b = b + byte_t'($urandom_range(1, 255));
      end
    end else if (kind == 7) begin
      queue_beat(1'b1, byte_t'($urandom));
    end else begin
      // small alphabet: many pairs and short repeats
      b   = byte_t'($urandom);
      len = $urandom_range(1, 6);
      repeat (len) queue_beat(1'b0, b + byte_t'($urandom_range(0, 2)));
    end
  endtask

  initial begin
    byte_t b;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty flush, extremes, short run, long run broken
    queue_beat(1'b1, 8'h00);
    queue_beat(1'b0, 8'h00);
    queue_beat(1'b1, 8'hFF);
    repeat (3) queue_beat(1'b0, 8'hFF);
    queue_beat(1'b0, 8'h11);
    queue_beat(1'b1, 8'h00);
    // short run into literals, tail pair split, run broken after sequence
    queue_beat(1'b0, 8'h55);
    queue_beat(1'b0, 8'hAA);
    queue_beat(1'b0, 8'hAA);
    queue_beat(1'b0, 8'h3C);
    queue_beat(1'b1, 8'h00);
    // sequence followed by a growing run, flushed sequence first
    queue_beat(1'b0, 8'h01);
    queue_beat(1'b0, 8'h02);
    repeat (4) queue_beat(1'b0, 8'h03);
    queue_beat(1'b1, 8'h00);
    // run of two broken with no sequence
    queue_beat(1'b0, 8'h7E);
    queue_beat(1'b0, 8'h7E);
    queue_beat(1'b0, 8'h81);
    queue_beat(1'b1, 8'h5A);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: ;
        1: begin
          cfg_write(REG_RUN_FLAG, 8'h00);
          cfg_write(REG_SEQ_FLAG, 8'hFF);
        end
        2: begin
          cfg_write(REG_RUN_FLAG, 8'hFF);
          cfg_write(REG_SEQ_FLAG, 8'h00);
        end
        default: begin
          cfg_write(REG_RUN_FLAG, byte_t'($urandom));
          cfg_write(REG_SEQ_FLAG, byte_t'($urandom));
        end
      endcase
      n_queued = 0;
      if (ph == 0) begin
        // full-length run behind a short sequence
        b = byte_t'($urandom);
        repeat (3) begin
          queue_beat(1'b0, b);
          b = b + byte_t'($urandom_range(1, 255));
        end
        repeat (MAXLEN) queue_beat(1'b0, b);
      end
      while (n_queued < PHASE_ITEMS) add_segment();
      queue_beat(1'b1, byte_t'($urandom));
      drain();
    end

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rlebc_pkg.sv
hdl/rlebc_cmd_fifo.sv
hdl/rlebc_front.sv
hdl/rlebc_back.sv
hdl/rle_byte_compressor.sv
tb/sv/tb_top.sv
